### src/bmi_pkg.sv
`default_nettype none

package bmi_pkg;

    localparam int IN_W        = 32;   // sample_value field width
    localparam int OUT_W       = 33;   // median_doubled / iqr_doubled width
    localparam int ST_W        = 2;    // status width
    localparam int OUT_DATA_W  = 72;   // two output fields padded to whole bytes
    localparam int DEF_MAX_SAMPLES = 32;
    localparam int DEF_SAMPLE_BITS = 32;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_SHORT = 2'd1;
    localparam logic [ST_W-1:0] ST_DROP  = 2'd2;

    // control into the row of sorting cells
    typedef struct packed {
        logic ins;      // insert the broadcast sample at its sorted place
        logic drain;    // shift every cell one place toward cell 0
    } t_cell_ctrl;

    // control into the quartile accumulators
    typedef struct packed {
        logic start;    // batch closed: latch pick positions, clear sums
        logic step;     // one sorted value is present at cell 0
    } t_stat_ctrl;

endpackage

`default_nettype wire

### src/bmi_cell.sv
`default_nettype none

module bmi_cell #(
    parameter int VAL_W = 32
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire bmi_pkg::t_cell_ctrl i_ctrl,
    input  wire [VAL_W-1:0]        i_sample,
    input  wire [VAL_W-1:0]        i_prev_value,
    input  wire                    i_prev_greater,
    input  wire                    i_prev_valid,
    input  wire [VAL_W-1:0]        i_next_value,
    output logic [VAL_W-1:0]       o_value,
    output logic                   o_greater,
    output logic                   o_valid
);
    import bmi_pkg::*;

    logic [VAL_W-1:0] r_value;
    logic             r_valid;
    logic             w_greater;

    // an empty cell counts as holding +infinity
    assign w_greater = !r_valid || (r_value > i_sample);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.drain) begin
            r_value <= i_next_value;
        end else if (i_ctrl.ins && w_greater) begin
            r_value <= i_prev_greater ? i_prev_value : i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.drain) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.ins) begin
            r_valid <= r_valid | i_prev_valid;
        end
    end

    assign o_value   = r_value;
    assign o_greater = w_greater;
    assign o_valid   = r_valid;

endmodule

`default_nettype wire

### src/bmi_stats.sv
`default_nettype none

module bmi_stats #(
    parameter int CNT_W = 6,
    parameter int VAL_W = 32
) (
    input  wire                    i_clk,
    input  wire bmi_pkg::t_stat_ctrl i_ctrl,
    input  wire [CNT_W-1:0]        i_count,
    input  wire [CNT_W-1:0]        i_idx,
    input  wire [VAL_W-1:0]        i_value,
    output logic [VAL_W:0]         o_med,
    output logic [VAL_W:0]         o_q1,
    output logic [VAL_W:0]         o_q3
);
    import bmi_pkg::*;

    localparam int AW = VAL_W + 1;

    logic [CNT_W-1:0] r_med_a, r_med_b, r_q1_a, r_q1_b, r_q3_a, r_q3_b;
    logic [AW-1:0]    r_med, r_q1, r_q3;
    logic [CNT_W-1:0] w_half, w_ceil;

    // value weighted by how many of the two pick positions match
    function automatic logic [AW-1:0] pick(
        input logic [CNT_W-1:0] idx,
        input logic [CNT_W-1:0] a,
        input logic [CNT_W-1:0] b,
        input logic [VAL_W-1:0] v
    );
        logic hit_a;
        logic hit_b;
        hit_a = (idx == a);
        hit_b = (idx == b);
        if (hit_a && hit_b) begin
            pick = {v, 1'b0};
        end else if (hit_a || hit_b) begin
            pick = {1'b0, v};
        end else begin
            pick = '0;
        end
    endfunction

    assign w_half = i_count >> 1;
    assign w_ceil = i_count - w_half;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            // odd run length: both picks land on the middle element
            r_med_a <= (i_count - CNT_W'(1)) >> 1;
            r_med_b <= i_count >> 1;
            r_q1_a  <= (w_half - CNT_W'(1)) >> 1;
            r_q1_b  <= w_half >> 1;
            r_q3_a  <= w_ceil + ((w_half - CNT_W'(1)) >> 1);
            r_q3_b  <= w_ceil + (w_half >> 1);
            r_med   <= '0;
            r_q1    <= '0;
            r_q3    <= '0;
        end else if (i_ctrl.step) begin
            r_med <= r_med + pick(i_idx, r_med_a, r_med_b, i_value);
            r_q1  <= r_q1 + pick(i_idx, r_q1_a, r_q1_b, i_value);
            r_q3  <= r_q3 + pick(i_idx, r_q3_a, r_q3_b, i_value);
        end
    end

    assign o_med = r_med;
    assign o_q1  = r_q1;
    assign o_q3  = r_q3;

endmodule

`default_nettype wire

### src/batch_median_and_iqr_unit.sv
`default_nettype none

// Batch median and interquartile range. Samples arrive one word per cycle on
// the slave stream, tlast marking the final sample of a batch; they are kept
// in ascending order by a row of MAX_SAMPLES insertion cells, each comparing
// the broadcast sample with its own value and taking either the sample or its
// lower neighbor's value. While a batch fills, one sample is taken every
// cycle. On the last sample the row drains through cell 0, one sorted value
// a cycle, and the accumulators pick the median and quartile positions. The
// result is posted once the output register is empty or being read; posting
// waits while the previous result still sits unread there. The slave side is
// not ready during drain and posting. The result word carries twice the
// median and twice Q3 - Q1, so half steps stay exact; of the n stored values,
// Q1 is the median of the lower floor(n/2) values and Q3 that of the values
// from ceil(n/2) on. tuser status: ok, fewer than two samples (iqr is zero),
// or samples dropped because the row was full (the result then comes from the
// stored ones). Only the low SAMPLE_BITS bits of each sample are used. A
// finished result waits in the output register while the next batch fills.
module batch_median_and_iqr_unit #(
    parameter int MAX_SAMPLES = bmi_pkg::DEF_MAX_SAMPLES,
    parameter int SAMPLE_BITS = bmi_pkg::DEF_SAMPLE_BITS
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // slave stream
    input  wire                           i_s_tvalid,
    output logic                          o_s_tready,
    input  wire [bmi_pkg::IN_W-1:0]       i_s_tdata,   // [31:0] sample_value
    input  wire                           i_s_tlast,   // last_sample
    // master stream
    output logic                          o_m_tvalid,
    input  wire                           i_m_tready,
    output logic [bmi_pkg::OUT_DATA_W-1:0] o_m_tdata,  // [32:0] median_doubled,
                                                       // [65:33] iqr_doubled, rest zero
    output logic [bmi_pkg::ST_W-1:0]      o_m_tuser    // [1:0] status
);
    import bmi_pkg::*;

    // samples wider than the input field keep only the field's bits
    localparam int VAL_W = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
    localparam int AW    = VAL_W + 1;
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SAMPLES);

    typedef enum logic [2:0] {
        S_FILL  = 3'b001,
        S_DRAIN = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_batch_n, n_batch_n;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [ST_W-1:0]  r_status, n_status;

    logic             r_out_valid, n_out_valid;
    logic [OUT_W-1:0] r_out_med, r_out_iqr;
    logic [ST_W-1:0]  r_out_status;

    logic             w_accept;
    logic             w_room;
    logic             w_load;
    logic [CNT_W-1:0] w_count_after;
    logic [VAL_W-1:0] w_sample;

    t_cell_ctrl       w_cell_ctrl;
    t_stat_ctrl       w_stat_ctrl;

    logic [VAL_W-1:0] w_value   [MAX_SAMPLES];
    logic             w_greater [MAX_SAMPLES];
    logic [MAX_SAMPLES-1:0] w_valid;

    logic [AW-1:0]    w_med, w_q1, w_q3;

    assign o_s_tready    = (r_state == S_FILL);
    assign w_accept      = i_s_tvalid && o_s_tready;
    assign w_room        = (r_count < MAX_CNT);
    assign w_count_after = w_room ? (r_count + CNT_W'(1)) : r_count;
    assign w_sample      = i_s_tdata[VAL_W-1:0];
    assign w_load        = (r_state == S_DONE) && (!r_out_valid || i_m_tready);

    assign w_cell_ctrl.ins   = w_accept && w_room;
    assign w_cell_ctrl.drain = (r_state == S_DRAIN);
    assign w_stat_ctrl.start = w_accept && i_s_tlast;
    assign w_stat_ctrl.step  = (r_state == S_DRAIN);

    // row of insertion cells; cell 0 holds the smallest value
    for (genvar g = 0; g < MAX_SAMPLES; g++) begin : g_cell
        logic [VAL_W-1:0] w_prev_value;
        logic             w_prev_greater;
        logic             w_prev_valid;
        logic [VAL_W-1:0] w_next_value;

        if (g == 0) begin : g_head
            assign w_prev_value   = w_sample;
            assign w_prev_greater = 1'b0;
            assign w_prev_valid   = 1'b1;
        end else begin : g_body
            assign w_prev_value   = w_value[g-1];
            assign w_prev_greater = w_greater[g-1];
            assign w_prev_valid   = w_valid[g-1];
        end

        if (g == MAX_SAMPLES - 1) begin : g_tail
            assign w_next_value = '0;
        end else begin : g_link
            assign w_next_value = w_value[g+1];
        end

        bmi_cell #(
            .VAL_W (VAL_W)
        ) u_cell (
            .i_clk          (i_clk),
            .i_rst_n        (i_rst_n),
            .i_ctrl         (w_cell_ctrl),
            .i_sample       (w_sample),
            .i_prev_value   (w_prev_value),
            .i_prev_greater (w_prev_greater),
            .i_prev_valid   (w_prev_valid),
            .i_next_value   (w_next_value),
            .o_value        (w_value[g]),
            .o_greater      (w_greater[g]),
            .o_valid        (w_valid[g])
        );
    end

    // median and quartile sums, fed from cell 0 during drain
    bmi_stats #(
        .CNT_W (CNT_W),
        .VAL_W (VAL_W)
    ) u_stats (
        .i_clk   (i_clk),
        .i_ctrl  (w_stat_ctrl),
        .i_count (w_count_after),
        .i_idx   (r_idx),
        .i_value (w_value[0]),
        .o_med   (w_med),
        .o_q1    (w_q1),
        .o_q3    (w_q3)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_batch_n   = r_batch_n;
        n_idx       = r_idx;
        n_status    = r_status;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_FILL: begin
                if (w_accept) begin
                    n_count = w_count_after;
                    n_ovf   = r_ovf || !w_room;
                    if (i_s_tlast) begin
                        n_batch_n = w_count_after;
                        n_idx     = '0;
                        if (w_count_after == CNT_W'(1)) begin
                            n_status = ST_SHORT;
                        end else if (r_ovf || !w_room) begin
                            n_status = ST_DROP;
                        end else begin
                            n_status = ST_OK;
                        end
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_idx = r_idx + CNT_W'(1);
                if (r_idx == r_batch_n - CNT_W'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_FILL;
                end
            end
            default: begin
                n_state = S_FILL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_batch_n <= n_batch_n;
        r_idx     <= n_idx;
        r_status  <= n_status;
        if (w_load) begin
            r_out_med    <= OUT_W'(w_med);
            r_out_iqr    <= (r_status == ST_SHORT) ? '0 : OUT_W'(w_q3 - w_q1);
            r_out_status <= r_status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'({r_out_iqr, r_out_med});
    assign o_m_tuser  = r_out_status;

    // the row's valid cells always match the running count while filling
    a_valid_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> ($countones(w_valid) == int'(r_count)))
        else $error("valid cells disagree with sample count");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("sample count beyond capacity");

    a_ovf_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_count == MAX_CNT))
        else $error("drop flag set with room left");

    a_drain_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN) |-> (r_idx < r_batch_n))
        else $error("drain index past batch length");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |=> (r_out_valid && $stable(r_out_med)))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`default_nettype none

module testbench;

    import bmi_pkg::*;

    localparam int CAPACITY     = DEF_MAX_SAMPLES;
    localparam int RESET_CYCLES = 7;
    localparam int IDLE_LIMIT   = 1000;   // cycles with no word moving on either side
    localparam int TAIL_CYCLES  = 2 * CAPACITY + 16;
    localparam int SAMPLE_GOAL  = 600;
    localparam int SHOWN_ERRORS = 10;

    // one batch outcome as the block posts it
    typedef struct packed {
        logic [OUT_W-1:0] median_x2;
        logic [OUT_W-1:0] iqr_x2;
        logic [ST_W-1:0]  status;
    } t_batch_summary;

    // keeps its own sorted copy of the open batch and the summaries still owed
    class median_iqr_scoreboard;
        logic [IN_W-1:0] held[$];
        bit              dropped;
        t_batch_summary  owed[$];
        int              mismatches;
        int              batches_checked;
        int              dropped_batches;
        int              single_batches;
        int              samples_taken;

        // twice the median of sorted positions lo .. hi-1
        function logic [OUT_W-1:0] median_x2_of(int lo, int hi);
            int span;
            int mid;
            span = hi - lo;
            mid  = lo + span / 2;
            if (span % 2 == 1) begin
                return {held[mid], 1'b0};
            end
            return {1'b0, held[mid-1]} + {1'b0, held[mid]};
        endfunction

        function void note_sample(logic [IN_W-1:0] value, logic last);
            int             pos;
            int             n;
            t_batch_summary sum;
            samples_taken++;
            if (held.size() < CAPACITY) begin
                pos = held.size();
                while (pos > 0 && held[pos-1] > value) begin
                    pos--;
                end
                held.insert(pos, value);
            end else begin
                dropped = 1'b1;
            end
            if (!last) begin
                return;
            end
            n = held.size();
            if (n < 2) begin
                sum.status    = ST_SHORT;
                sum.median_x2 = {held[0], 1'b0};
                sum.iqr_x2    = '0;
            end else begin
                sum.status    = dropped ? ST_DROP : ST_OK;
                sum.median_x2 = median_x2_of(0, n);
                sum.iqr_x2    = median_x2_of((n + 1) / 2, n) - median_x2_of(0, n / 2);
            end
            owed.insert(owed.size(), sum);
            held.delete();
            dropped = 1'b0;
        endfunction

        function void report(string what, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
            mismatches++;
            if (mismatches <= SHOWN_ERRORS) begin
                $display("mismatch in %s: expected %0h, got %0h", what, want, got);
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] data, logic [ST_W-1:0] status);
            t_batch_summary want;
            if (owed.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_ERRORS) begin
                    $display("result word with no batch closed: data %0h status %0d",
                             data, status);
                end
                return;
            end
            want = owed.pop_front();
            batches_checked++;
            if (want.status == ST_DROP) dropped_batches++;
            if (want.status == ST_SHORT) single_batches++;
            if (data[OUT_W-1:0] !== want.median_x2) begin
                report("median_doubled", want.median_x2, data[OUT_W-1:0]);
            end
            if (data[2*OUT_W-1:OUT_W] !== want.iqr_x2) begin
                report("iqr_doubled", want.iqr_x2, data[2*OUT_W-1:OUT_W]);
            end
            if (status !== want.status) begin
                report("status", {{(OUT_W-ST_W){1'b0}}, want.status},
                       {{(OUT_W-ST_W){1'b0}}, status});
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_W-1:0]       i_s_tdata = '0;     // [31:0] sample_value
    logic                  i_s_tlast = 1'b0;   // last_sample
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b1;
    logic [OUT_DATA_W-1:0] o_m_tdata;          // [32:0] median_doubled, [65:33] iqr_doubled
    logic [ST_W-1:0]       o_m_tuser;          // [1:0] status

    median_iqr_scoreboard sb = new();

    int idle_cycles = 0;
    int burst_left  = 0;
    logic [15:0] ready_pattern = '1;
    int          pattern_age   = 0;

    batch_median_and_iqr_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // 12 unit period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // sink side: tready follows a rotating pattern that is swapped when pattern_age wraps;
    // some patterns never stall, some stall most of the time
    always @(negedge i_clk) begin
        i_m_tready <= ready_pattern[0];
        if (pattern_age == 47) begin
            pattern_age <= 0;
            case ($urandom_range(0, 3))
                0: begin
                    ready_pattern <= '1;
                end
                1: begin
                    ready_pattern <= 16'($urandom) | 16'h8000;
                end
                2: begin
                    ready_pattern <= 16'($urandom) | 16'($urandom);
                end
                default: begin
                    // mostly stalled, but never a whole pattern of stall
                    ready_pattern <= (16'($urandom) & 16'($urandom)) | 16'h8000;
                end
            endcase
        end else begin
            pattern_age   <= pattern_age + 1;
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // monitor: both handshakes are sampled at the rising edge, plus the idle watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                sb.note_sample(i_s_tdata, i_s_tlast);
            end
            if (o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata, o_m_tuser);
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // source side: called just after a falling edge, returns just after one;
    // words go out in bursts of random length with random gaps between them
    task automatic push_sample(input logic [IN_W-1:0] value, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tlast  <= last;
        @(posedge i_clk);
        while (!o_s_tready) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // sample content styles: full range, a narrow band full of repeats,
    // the two extremes mixed in, and values near the top of the range
    function automatic logic [IN_W-1:0] pick_value(input int style);
        case (style)
            0: return IN_W'($urandom);
            1: return IN_W'($urandom_range(0, 7));
            2: begin
                case ($urandom_range(0, 2))
                    0: return '0;
                    1: return '1;
                    default: return IN_W'($urandom);
                endcase
            end
            default: return ~IN_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_batch(input int size);
        int style;
        style = $urandom_range(0, 3);
        for (int k = 0; k < size; k++) begin
            push_sample(pick_value(style), k == size - 1);
        end
    endtask

    initial begin
        int size;
        int pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-sample batches at both ends of the range
        push_sample('0, 1'b1);
        push_sample('1, 1'b1);
        // two samples, largest first: widest possible spread
        push_sample('1, 1'b0);
        push_sample('0, 1'b1);
        // descending run of three, odd size
        push_sample(32'd300, 1'b0);
        push_sample(32'd200, 1'b0);
        push_sample(32'd100, 1'b1);
        // all equal samples
        repeat (3) push_sample(32'd7, 1'b0);
        push_sample(32'd7, 1'b1);
        // five samples with repeated maximum and the top bit alone
        push_sample('1, 1'b0);
        push_sample(32'd1, 1'b0);
        push_sample('1, 1'b0);
        push_sample('0, 1'b0);
        push_sample(32'h8000_0000, 1'b1);
        // six arbitrary samples, even size with odd halves
        for (int k = 0; k < 6; k++) begin
            push_sample(IN_W'($urandom), k == 5);
        end

        // exactly full, then full with the extra sample being the last one
        send_batch(CAPACITY);
        send_batch(CAPACITY + 1);

        // random batches: mostly short, some single, some full, some overflowing
        while (sb.samples_taken < SAMPLE_GOAL) begin
            pick = $urandom_range(0, 9);
            case (pick)
                0: size = 1;
                1: size = CAPACITY;
                2: size = $urandom_range(CAPACITY + 1, CAPACITY + 8);
                default: size = $urandom_range(2, 16);
            endcase
            send_batch(size);
        end
        i_s_tvalid <= 1'b0;
        i_s_tlast  <= 1'b0;

        // wait for every owed summary, then let any stray word show up
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d samples in %0d batches checked: %0d single-sample, %0d with dropped samples",
                 sb.samples_taken, sb.batches_checked, sb.single_batches, sb.dropped_batches);
        $display("%0d mismatches, %0d summaries never posted", sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

### batch_median_and_iqr_unit.f
src/bmi_pkg.sv
src/bmi_cell.sv
src/bmi_stats.sv
src/batch_median_and_iqr_unit.sv
tb/sv/testbench.sv
